// ===== hdl/fma_pkg.sv =====
// ----------------------------------------------------------------------
// fma_pkg: shared types and constants of the fused multiply-add unit
// Field layouts of both precisions, the internal operand record and a
// leading zero counter used by operand decode and final normalization.
// ----------------------------------------------------------------------
package fma_pkg;

	localparam int WORD_W       = 64;
	localparam int SP_EXP_BITS  = 8;
	localparam int SP_MANT_BITS = 24;
	localparam int DP_EXP_BITS  = 11;
	localparam int DP_MANT_BITS = 53;

	// Internal significand: both precisions are carried at double width.
	localparam int MANT_W = DP_MANT_BITS;
	localparam int EXP_W  = 14;

	localparam logic signed [EXP_W-1:0] SP_EMIN     = -14'sd149;
	localparam logic signed [EXP_W-1:0] DP_EMIN     = -14'sd1074;
	localparam logic signed [EXP_W-1:0] SP_BIAS_LSB = 14'sd150;
	localparam logic signed [EXP_W-1:0] DP_BIAS_LSB = 14'sd1075;
	localparam logic signed [EXP_W-1:0] SP_ALIGN    = 14'sd29;

	// Decoded operand: significand normalized so that its top bit is set
	// (unless the operand is zero), exp is the weight of its lowest bit.
	typedef struct packed {
		logic                    sign;
		logic                    is_nan;
		logic                    is_inf;
		logic                    is_zero;
		logic [MANT_W-1:0]       mant;
		logic signed [EXP_W-1:0] exp;
	} fma_opnd_t;

	// Leading zero count of a nonzero 64-bit word in six halving steps.
	function automatic logic [5:0] lzc64(input logic [63:0] v);
		logic [63:0] x;
		logic [5:0]  n;
		x = v;
		n = '0;
		if (x[63:32] == '0) begin
			n[5] = 1'b1;
			x = {x[31:0], 32'b0};
		end
		if (x[63:48] == '0) begin
			n[4] = 1'b1;
			x = {x[47:0], 16'b0};
		end
		if (x[63:56] == '0) begin
			n[3] = 1'b1;
			x = {x[55:0], 8'b0};
		end
		if (x[63:60] == '0) begin
			n[2] = 1'b1;
			x = {x[59:0], 4'b0};
		end
		if (x[63:62] == '0) begin
			n[1] = 1'b1;
			x = {x[61:0], 2'b0};
		end
		if (!x[63]) begin
			n[0] = 1'b1;
		end
		return n;
	endfunction

endpackage

// ===== hdl/fma_in_if.sv =====
// ----------------------------------------------------------------------
// fma_in_if: operand channel
// Valid/ready channel carrying the precision select and three operands.
// ----------------------------------------------------------------------
interface fma_in_if import fma_pkg::*;;
	logic              valid;
	logic              ready;
	logic              cmd;
	logic [WORD_W-1:0] mult_a;
	logic [WORD_W-1:0] mult_b;
	logic [WORD_W-1:0] addend;

	modport source (output valid, cmd, mult_a, mult_b, addend, input ready);
	modport sink (input valid, cmd, mult_a, mult_b, addend, output ready);
endinterface

// ===== hdl/fma_out_if.sv =====
// ----------------------------------------------------------------------
// fma_out_if: result channel
// Valid/ready channel carrying one rounded result word.
// ----------------------------------------------------------------------
interface fma_out_if import fma_pkg::*;;
	logic              valid;
	logic              ready;
	logic [WORD_W-1:0] sum_out;

	modport source (output valid, sum_out, input ready);
	modport sink (input valid, sum_out, output ready);
endinterface

// ===== hdl/fma_unpack.sv =====
// ----------------------------------------------------------------------
// fma_unpack: operand decode
// Splits one operand word into class flags, sign, a normalized
// significand and the weight of its lowest bit.
// ----------------------------------------------------------------------
module fma_unpack import fma_pkg::*; (
	input  logic              cmd,
	input  logic [WORD_W-1:0] word,
	output fma_opnd_t         opnd
);

	localparam int SP_FB = SP_MANT_BITS - 1;
	localparam int DP_FB = DP_MANT_BITS - 1;

	logic [SP_EXP_BITS-1:0]  e_sp;
	logic [SP_FB-1:0]        f_sp;
	logic [DP_EXP_BITS-1:0]  e_dp;
	logic [DP_FB-1:0]        f_dp;
	logic                    exp_ones;
	logic                    exp_zero;
	logic                    frac_zero;
	logic [MANT_W-1:0]       m_raw;
	logic signed [EXP_W-1:0] e_raw;
	logic [5:0]              lz;

	assign e_sp = word[SP_FB +: SP_EXP_BITS];
	assign f_sp = word[SP_FB-1:0];
	assign e_dp = word[DP_FB +: DP_EXP_BITS];
	assign f_dp = word[DP_FB-1:0];

	always_comb begin
		if (cmd) begin
			exp_ones  = &e_dp;
			exp_zero  = (e_dp == '0);
			frac_zero = (f_dp == '0);
			m_raw     = {!exp_zero, f_dp};
			e_raw     = exp_zero ? DP_EMIN
			                     : $signed({{(EXP_W-DP_EXP_BITS){1'b0}}, e_dp}) - DP_BIAS_LSB;
			opnd.sign = word[WORD_W-1];
		end else begin
			exp_ones  = &e_sp;
			exp_zero  = (e_sp == '0);
			frac_zero = (f_sp == '0);
			// Single precision is left-justified in the wide significand.
			m_raw     = {!exp_zero, f_sp, {(MANT_W-SP_MANT_BITS){1'b0}}};
			e_raw     = (exp_zero ? SP_EMIN
			                      : $signed({{(EXP_W-SP_EXP_BITS){1'b0}}, e_sp}) - SP_BIAS_LSB)
			            - SP_ALIGN;
			opnd.sign = word[SP_EXP_BITS+SP_MANT_BITS-1];
		end
		lz           = lzc64({m_raw, {(64-MANT_W){1'b0}}});
		opnd.is_nan  = exp_ones && !frac_zero;
		opnd.is_inf  = exp_ones && frac_zero;
		opnd.is_zero = exp_zero && frac_zero;
		opnd.mant    = m_raw << lz;
		opnd.exp     = e_raw - $signed({{(EXP_W-6){1'b0}}, lz});
	end

endmodule

// ===== hdl/fused_multiply_add.sv =====
// Throughput: one word per cycle while result.ready is high; the rate is
// set by the nine-stage pipeline, whose stages each hold one word and
// load when they are empty or when the stage after them loads.
// Reset clears only the stage valid bits; no word is in flight after it.
// ----------------------------------------------------------------------
// fused_multiply_add: IEEE-754 binary32/binary64 fused multiply-add
// Computes a*b+c exactly and rounds once to nearest, ties to even.
// ----------------------------------------------------------------------
module fused_multiply_add import fma_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	fma_in_if.sink   operands,
	fma_out_if.source result
);

	// Stage map:
	//  s1  decode operands, normalize subnormal significands, special cases
	//  s2  four partial products of 27- and 26-bit halves, exponent difference and alignment
	//  s3  product sum, addend alignment with sticky collection
	//  s4  wide add or subtract of product and addend
	//  s5  magnitude (negate when the addend was larger)
	//  s6  leading zero count per 41-bit chunk
	//  s7  leading one position and rounding position
	//  s8  shift to the rounding position, round and sticky bits
	//  s9  round, exponent overflow, pack (output register)
	//
	// The sum is formed in a fixed 163-bit window. The 106-bit product sits
	// at bits 2..107 and the addend is right shifted into place; when the
	// addend lies far above the product, the addend is pinned at bit 110
	// and the product collapses to a sticky bit at bit 0.

	localparam int LO_W    = 27;
	localparam int HI_W    = MANT_W - LO_W;
	localparam int PROD_W  = 2 * MANT_W;
	localparam int ADD_POS = PROD_W + 4;
	localparam int WIN_W   = ADD_POS + MANT_W;
	localparam int SUM_W   = WIN_W + 1;
	localparam int CHUNK_W = 41;
	localparam int N_CHUNK = SUM_W / CHUNK_W;
	localparam int Q_W     = MANT_W + 1;

	localparam logic signed [EXP_W-1:0] CLAMP_D   = 14'sd108;
	localparam logic signed [EXP_W-1:0] ADD_POS_E = 14'sd110;
	localparam logic signed [EXP_W-1:0] GUARD_E   = 14'sd2;
	localparam logic signed [EXP_W-1:0] WIN_W_E   = 14'sd163;
	localparam logic signed [EXP_W-1:0] SUM_W_E   = 14'sd164;
	localparam logic signed [EXP_W-1:0] SP_FB_E   = 14'sd23;
	localparam logic signed [EXP_W-1:0] DP_FB_E   = 14'sd52;
	localparam logic signed [EXP_W-1:0] SP_EMAX   = 14'sd255;
	localparam logic signed [EXP_W-1:0] DP_EMAX   = 14'sd2047;

	localparam logic [WORD_W-1:0] SP_QBIT = 64'h0000_0000_0040_0000;
	localparam logic [WORD_W-1:0] DP_QBIT = 64'h0008_0000_0000_0000;
	localparam logic [WORD_W-1:0] SP_SBIT = 64'h0000_0000_8000_0000;
	localparam logic [WORD_W-1:0] DP_SBIT = 64'h8000_0000_0000_0000;
	localparam logic [WORD_W-1:0] SP_INF  = 64'h0000_0000_7F80_0000;
	localparam logic [WORD_W-1:0] DP_INF  = 64'h7FF0_0000_0000_0000;

	// ------------------------------------------------------------------
	// Handshake. Each stage loads when it is empty or the stage after it
	// loads, so bubbles close up and a stalled output holds its word.
	// ------------------------------------------------------------------
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8, vld_s9;
	logic en_s1, en_s2, en_s3, en_s4, en_s5, en_s6, en_s7, en_s8, en_s9;

	assign en_s9 = !vld_s9 || result.ready;
	assign en_s8 = !vld_s8 || en_s9;
	assign en_s7 = !vld_s7 || en_s8;
	assign en_s6 = !vld_s6 || en_s7;
	assign en_s5 = !vld_s5 || en_s6;
	assign en_s4 = !vld_s4 || en_s5;
	assign en_s3 = !vld_s3 || en_s4;
	assign en_s2 = !vld_s2 || en_s3;
	assign en_s1 = !vld_s1 || en_s2;

	assign operands.ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
			vld_s9 <= 1'b0;
		end else begin
			if (en_s1) vld_s1 <= operands.valid;
			if (en_s2) vld_s2 <= vld_s1;
			if (en_s3) vld_s3 <= vld_s2;
			if (en_s4) vld_s4 <= vld_s3;
			if (en_s5) vld_s5 <= vld_s4;
			if (en_s6) vld_s6 <= vld_s5;
			if (en_s7) vld_s7 <= vld_s6;
			if (en_s8) vld_s8 <= vld_s7;
			if (en_s9) vld_s9 <= vld_s8;
		end
	end

	// ------------------------------------------------------------------
	// Stage 1: decode and special cases.
	// ------------------------------------------------------------------
	fma_opnd_t         ua, ub, uc;
	logic [WORD_W-1:0] a_w, b_w, c_w;
	logic [WORD_W-1:0] qbit, sbit, infb, dnan;
	logic              sp_c;
	logic              spec_c;
	logic [WORD_W-1:0] spec_val_c;

	fma_unpack u_unpack_a (.cmd(operands.cmd), .word(operands.mult_a), .opnd(ua));
	fma_unpack u_unpack_b (.cmd(operands.cmd), .word(operands.mult_b), .opnd(ub));
	fma_unpack u_unpack_c (.cmd(operands.cmd), .word(operands.addend), .opnd(uc));

	always_comb begin
		// In single precision the upper halves are ignored and returned as zero.
		a_w  = operands.cmd ? operands.mult_a : {32'b0, operands.mult_a[31:0]};
		b_w  = operands.cmd ? operands.mult_b : {32'b0, operands.mult_b[31:0]};
		c_w  = operands.cmd ? operands.addend : {32'b0, operands.addend[31:0]};
		qbit = operands.cmd ? DP_QBIT : SP_QBIT;
		sbit = operands.cmd ? DP_SBIT : SP_SBIT;
		infb = operands.cmd ? DP_INF : SP_INF;
		dnan = sbit | infb | qbit;
		sp_c = ua.sign ^ ub.sign;
		spec_c     = 1'b1;
		spec_val_c = '0;
		// Order matters: a NaN in a or b wins over an invalid product, which
		// in turn wins over a NaN in c.
		priority if (ua.is_nan) begin
			spec_val_c = a_w | qbit;
		end else if (ub.is_nan) begin
			spec_val_c = b_w | qbit;
		end else if ((ua.is_inf && ub.is_zero) || (ua.is_zero && ub.is_inf)) begin
			spec_val_c = dnan;
		end else if (uc.is_nan) begin
			spec_val_c = c_w | qbit;
		end else if (ua.is_inf || ub.is_inf) begin
			if (uc.is_inf && (uc.sign != sp_c)) begin
				spec_val_c = dnan;
			end else begin
				spec_val_c = (sp_c ? sbit : '0) | infb;
			end
		end else if (uc.is_inf) begin
			spec_val_c = c_w;
		end else if (ua.is_zero || ub.is_zero) begin
			if (uc.is_zero) begin
				spec_val_c = (sp_c && uc.sign) ? sbit : '0;
			end else begin
				spec_val_c = c_w;
			end
		end else begin
			spec_c = 1'b0;
		end
	end

	logic                    cmd_s1, spec_s1, sp_s1, sc_s1, zc_s1;
	logic [WORD_W-1:0]       spec_val_s1;
	logic [MANT_W-1:0]       ma_s1, mb_s1, mc_s1;
	logic signed [EXP_W-1:0] ea_s1, eb_s1, ec_s1;

	always_ff @(posedge clk) begin
		if (en_s1) begin
			cmd_s1      <= operands.cmd;
			spec_s1     <= spec_c;
			spec_val_s1 <= spec_val_c;
			sp_s1       <= sp_c;
			sc_s1       <= uc.sign;
			zc_s1       <= uc.is_zero;
			ma_s1       <= ua.mant;
			mb_s1       <= ub.mant;
			mc_s1       <= uc.mant;
			ea_s1       <= ua.exp;
			eb_s1       <= ub.exp;
			ec_s1       <= uc.exp;
		end
	end

	// ------------------------------------------------------------------
	// Stage 2: partial products and alignment distance.
	// ------------------------------------------------------------------
	logic signed [EXP_W-1:0] pe_c, d_c, r_full_c;
	logic                    clamp_c;
	logic [2*LO_W-1:0]       p00_c;
	logic [LO_W+HI_W-1:0]    p01_c, p10_c;
	logic [2*HI_W-1:0]       p11_c;

	assign pe_c     = ea_s1 + eb_s1;
	assign d_c      = ec_s1 - pe_c;
	assign clamp_c  = !zc_s1 && (d_c > CLAMP_D);
	assign r_full_c = CLAMP_D - d_c;
	assign p00_c    = ma_s1[LO_W-1:0] * mb_s1[LO_W-1:0];
	assign p01_c    = ma_s1[LO_W-1:0] * mb_s1[MANT_W-1:LO_W];
	assign p10_c    = ma_s1[MANT_W-1:LO_W] * mb_s1[LO_W-1:0];
	assign p11_c    = ma_s1[MANT_W-1:LO_W] * mb_s1[MANT_W-1:LO_W];

	logic                    cmd_s2, spec_s2, sp_s2, sc_s2, zc_s2, clamp_s2, far_s2;
	logic [WORD_W-1:0]       spec_val_s2;
	logic [2*LO_W-1:0]       pp00_s2;
	logic [LO_W+HI_W-1:0]    pp01_s2, pp10_s2;
	logic [2*HI_W-1:0]       pp11_s2;
	logic [7:0]              rsh_s2;
	logic signed [EXP_W-1:0] eb0_s2;
	logic [MANT_W-1:0]       mc_s2;

	always_ff @(posedge clk) begin
		if (en_s2) begin
			cmd_s2      <= cmd_s1;
			spec_s2     <= spec_s1;
			spec_val_s2 <= spec_val_s1;
			sp_s2       <= sp_s1;
			sc_s2       <= sc_s1;
			zc_s2       <= zc_s1;
			clamp_s2    <= clamp_c;
			far_s2      <= (r_full_c >= WIN_W_E);
			rsh_s2      <= r_full_c[7:0];
			eb0_s2      <= clamp_c ? (ec_s1 - ADD_POS_E) : (pe_c - GUARD_E);
			mc_s2       <= mc_s1;
			pp00_s2     <= p00_c;
			pp01_s2     <= p01_c;
			pp10_s2     <= p10_c;
			pp11_s2     <= p11_c;
		end
	end

	// ------------------------------------------------------------------
	// Stage 3: product sum and addend alignment.
	// ------------------------------------------------------------------
	logic [PROD_W-1:0] prod_c;
	logic [WIN_W-1:0]  cfull_c, cmask_c, add_c;

	assign prod_c = (PROD_W'(pp11_s2) << (2 * LO_W)) + (PROD_W'(pp01_s2) << LO_W)
	              + (PROD_W'(pp10_s2) << LO_W) + PROD_W'(pp00_s2);
	assign cfull_c = {mc_s2, {ADD_POS{1'b0}}};
	assign cmask_c = (WIN_W'(1) << rsh_s2) - WIN_W'(1);

	always_comb begin
		priority if (zc_s2) begin
			add_c = '0;
		end else if (clamp_s2) begin
			add_c = cfull_c;
		end else if (far_s2) begin
			add_c = WIN_W'(1);
		end else begin
			add_c = (cfull_c >> rsh_s2) | WIN_W'(|(cfull_c & cmask_c));
		end
	end

	logic                    cmd_s3, spec_s3, sp_s3, sc_s3, clamp_s3;
	logic [WORD_W-1:0]       spec_val_s3;
	logic [PROD_W-1:0]       prod_s3;
	logic [WIN_W-1:0]        add_s3;
	logic signed [EXP_W-1:0] eb0_s3;

	always_ff @(posedge clk) begin
		if (en_s3) begin
			cmd_s3      <= cmd_s2;
			spec_s3     <= spec_s2;
			spec_val_s3 <= spec_val_s2;
			sp_s3       <= sp_s2;
			sc_s3       <= sc_s2;
			clamp_s3    <= clamp_s2;
			eb0_s3      <= eb0_s2;
			prod_s3     <= prod_c;
			add_s3      <= add_c;
		end
	end

	// ------------------------------------------------------------------
	// Stage 4: add or subtract in the window.
	// ------------------------------------------------------------------
	logic [WIN_W-1:0] x_c;
	logic [SUM_W:0]   raw_c;
	logic             sub_c;

	assign x_c   = clamp_s3 ? WIN_W'(1) : {{(WIN_W-PROD_W-2){1'b0}}, prod_s3, 2'b0};
	assign sub_c = sp_s3 != sc_s3;
	assign raw_c = sub_c ? ({2'b0, x_c} - {2'b0, add_s3}) : ({2'b0, x_c} + {2'b0, add_s3});

	logic                    cmd_s4, spec_s4, neg_s4, sgn_s4;
	logic [WORD_W-1:0]       spec_val_s4;
	logic [SUM_W-1:0]        raw_s4;
	logic signed [EXP_W-1:0] eb0_s4;

	always_ff @(posedge clk) begin
		if (en_s4) begin
			cmd_s4      <= cmd_s3;
			spec_s4     <= spec_s3;
			spec_val_s4 <= spec_val_s3;
			neg_s4      <= raw_c[SUM_W];
			sgn_s4      <= raw_c[SUM_W] ? sc_s3 : sp_s3;
			raw_s4      <= raw_c[SUM_W-1:0];
			eb0_s4      <= eb0_s3;
		end
	end

	// ------------------------------------------------------------------
	// Stage 5: magnitude.
	// ------------------------------------------------------------------
	logic                    cmd_s5, spec_s5, sgn_s5;
	logic [WORD_W-1:0]       spec_val_s5;
	logic [SUM_W-1:0]        m_s5;
	logic signed [EXP_W-1:0] eb0_s5;

	always_ff @(posedge clk) begin
		if (en_s5) begin
			cmd_s5      <= cmd_s4;
			spec_s5     <= spec_s4;
			spec_val_s5 <= spec_val_s4;
			sgn_s5      <= sgn_s4;
			m_s5        <= neg_s4 ? (~raw_s4 + SUM_W'(1)) : raw_s4;
			eb0_s5      <= eb0_s4;
		end
	end

	// ------------------------------------------------------------------
	// Stage 6: leading zero count of each chunk.
	// ------------------------------------------------------------------
	logic                    cmd_s6, spec_s6, sgn_s6;
	logic [WORD_W-1:0]       spec_val_s6;
	logic [SUM_W-1:0]        m_s6;
	logic signed [EXP_W-1:0] eb0_s6;
	logic [5:0]              lz_s6 [N_CHUNK];
	logic [N_CHUNK-1:0]      nz_s6;

	always_ff @(posedge clk) begin
		if (en_s6) begin
			cmd_s6      <= cmd_s5;
			spec_s6     <= spec_s5;
			spec_val_s6 <= spec_val_s5;
			sgn_s6      <= sgn_s5;
			m_s6        <= m_s5;
			eb0_s6      <= eb0_s5;
			for (int j = 0; j < N_CHUNK; j++) begin
				lz_s6[j] <= lzc64({m_s5[j*CHUNK_W +: CHUNK_W], {(64-CHUNK_W){1'b0}}});
				nz_s6[j] <= |m_s5[j*CHUNK_W +: CHUNK_W];
			end
		end
	end

	// ------------------------------------------------------------------
	// Stage 7: leading one and rounding position. The rounding position
	// is p-1 below the leading one, but never below the subnormal floor.
	// ------------------------------------------------------------------
	logic [7:0]              top_c;
	logic signed [EXP_W-1:0] fb_c, emin_c, lsb_cand_c, lsb_c;

	always_comb begin
		top_c = '0;
		for (int j = 0; j < N_CHUNK; j++) begin
			if (nz_s6[j]) begin
				top_c = 8'(j * CHUNK_W + CHUNK_W - 1) - {2'b0, lz_s6[j]};
			end
		end
		fb_c       = cmd_s6 ? DP_FB_E : SP_FB_E;
		emin_c     = cmd_s6 ? DP_EMIN : SP_EMIN;
		lsb_cand_c = eb0_s6 + $signed({{(EXP_W-8){1'b0}}, top_c}) - fb_c;
		lsb_c      = (lsb_cand_c < emin_c) ? emin_c : lsb_cand_c;
	end

	logic                    cmd_s7, spec_s7, sgn_s7, zero_s7;
	logic [WORD_W-1:0]       spec_val_s7;
	logic [SUM_W-1:0]        m_s7;
	logic signed [EXP_W-1:0] lsb_s7, s_s7;

	always_ff @(posedge clk) begin
		if (en_s7) begin
			cmd_s7      <= cmd_s6;
			spec_s7     <= spec_s6;
			spec_val_s7 <= spec_val_s6;
			sgn_s7      <= sgn_s6;
			zero_s7     <= (nz_s6 == '0);
			m_s7        <= m_s6;
			lsb_s7      <= lsb_c;
			s_s7        <= lsb_c - eb0_s6;
		end
	end

	// ------------------------------------------------------------------
	// Stage 8: bring the significand to the rounding position. A negative
	// distance means the exact sum has fewer bits than the precision.
	// ------------------------------------------------------------------
	logic signed [EXP_W-1:0] negs_c;
	logic [7:0]              sh_c, shm1_c;
	logic [SUM_W-1:0]        smask_c, shifted_c;
	logic [Q_W-1:0]          q_c;
	logic                    rnd_c, stk_c;

	always_comb begin
		negs_c    = -s_s7;
		sh_c      = s_s7[7:0];
		shm1_c    = sh_c - 8'd1;
		smask_c   = (SUM_W'(1) << shm1_c) - SUM_W'(1);
		shifted_c = m_s7 >> sh_c;
		priority if (s_s7 <= 14'sd0) begin
			q_c   = m_s7[Q_W-1:0] << negs_c[5:0];
			rnd_c = 1'b0;
			stk_c = 1'b0;
		end else if (s_s7 > SUM_W_E) begin
			q_c   = '0;
			rnd_c = 1'b0;
			stk_c = |m_s7;
		end else begin
			q_c   = shifted_c[Q_W-1:0];
			rnd_c = m_s7[shm1_c];
			stk_c = |(m_s7 & smask_c);
		end
	end

	logic                    cmd_s8, spec_s8, sgn_s8, zero_s8, rnd_s8, stk_s8;
	logic [WORD_W-1:0]       spec_val_s8;
	logic [Q_W-1:0]          q_s8;
	logic signed [EXP_W-1:0] lsb_s8;

	always_ff @(posedge clk) begin
		if (en_s8) begin
			cmd_s8      <= cmd_s7;
			spec_s8     <= spec_s7;
			spec_val_s8 <= spec_val_s7;
			sgn_s8      <= sgn_s7;
			zero_s8     <= zero_s7;
			q_s8        <= q_c;
			rnd_s8      <= rnd_c;
			stk_s8      <= stk_c;
			lsb_s8      <= lsb_s7;
		end
	end

	// ------------------------------------------------------------------
	// Stage 9: round to nearest even, renormalize a carry out, pack.
	// A subnormal that rounds up to the smallest normal needs no special
	// handling: the hidden bit carries into the exponent field.
	// ------------------------------------------------------------------
	logic [Q_W-1:0]                       qr_c, qn_c;
	logic signed [EXP_W-1:0]              lsbn_c, k_c, e_c, emin9_c, emax9_c;
	logic                                 carry_c, hidden_c, ovf_c;
	logic [DP_EXP_BITS+DP_MANT_BITS-2:0]  dp_body_c;
	logic [SP_EXP_BITS+SP_MANT_BITS-2:0]  sp_body_c;
	logic [WORD_W-1:0]                    word_c;

	always_comb begin
		qr_c     = q_s8 + Q_W'(rnd_s8 && (stk_s8 || q_s8[0]));
		carry_c  = cmd_s8 ? qr_c[DP_MANT_BITS] : qr_c[SP_MANT_BITS];
		qn_c     = carry_c ? (qr_c >> 1) : qr_c;
		lsbn_c   = carry_c ? (lsb_s8 + 14'sd1) : lsb_s8;
		emin9_c  = cmd_s8 ? DP_EMIN : SP_EMIN;
		emax9_c  = cmd_s8 ? DP_EMAX : SP_EMAX;
		hidden_c = cmd_s8 ? qn_c[DP_MANT_BITS-1] : qn_c[SP_MANT_BITS-1];
		k_c      = lsbn_c - emin9_c;
		e_c      = k_c + $signed({{(EXP_W-1){1'b0}}, hidden_c});
		ovf_c    = e_c >= emax9_c;
		dp_body_c = {k_c[DP_EXP_BITS-1:0], {(DP_MANT_BITS-1){1'b0}}}
		          + {{(DP_EXP_BITS-1){1'b0}}, qn_c[DP_MANT_BITS-1:0]};
		sp_body_c = {k_c[SP_EXP_BITS-1:0], {(SP_MANT_BITS-1){1'b0}}}
		          + {{(SP_EXP_BITS-1){1'b0}}, qn_c[SP_MANT_BITS-1:0]};
		priority if (spec_s8) begin
			word_c = spec_val_s8;
		end else if (zero_s8) begin
			// Exact cancellation gives positive zero.
			word_c = '0;
		end else if (cmd_s8) begin
			word_c = (sgn_s8 ? DP_SBIT : '0) | (ovf_c ? DP_INF : {1'b0, dp_body_c});
		end else begin
			word_c = (sgn_s8 ? SP_SBIT : '0) | (ovf_c ? SP_INF : {33'b0, sp_body_c});
		end
	end

	logic [WORD_W-1:0] sum_s9;

	always_ff @(posedge clk) begin
		if (en_s9) begin
			sum_s9 <= word_c;
		end
	end

	assign result.valid   = vld_s9;
	assign result.sum_out = sum_s9;

`ifndef NO_ASSERTIONS
	// An empty first stage must always take a new word.
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!vld_s1 |-> operands.ready)
		else $error("operand channel stalled with an empty first stage");

	// Before rounding, the significand never exceeds the precision.
	a_q_fits: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s8 && !spec_s8 && !zero_s8) |->
		(cmd_s8 ? !q_s8[DP_MANT_BITS] : (q_s8[Q_W-1:SP_MANT_BITS] == '0)))
		else $error("pre-rounding significand too wide");

	// A held middle stage keeps its word.
	a_hold_mid: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s5 && !en_s5) |=> vld_s5)
		else $error("stalled word lost in stage 5");
`endif

endmodule

// ===== tb/tb_fused_multiply_add.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------
// tb_fused_multiply_add: self-checking bench of the fused multiply-add unit
// A directed table and then random words go in. Some operands are special
// values and some addends nearly cancel the product. Every result word is
// compared with a known table value or a bit-exact model of single-rounding a*b+c.
// ----------------------------------------------------------------------
module tb_fused_multiply_add import fma_pkg::*;;

	localparam int N_RANDOM  = 930;
	localparam int MAX_CYCLE = 400000;
	localparam int WIN_TOP   = 253;
	localparam logic PREC_SP = 1'b0;
	localparam logic PREC_DP = 1'b1;

	// One row of the directed table. When known is set, want holds the
	// result read straight off the IEEE rules and replaces the model's value.
	typedef struct packed {
		logic              cmd;
		logic [WORD_W-1:0] a;
		logic [WORD_W-1:0] b;
		logic [WORD_W-1:0] c;
		logic              known;
		logic [WORD_W-1:0] want;
	} stim_row_t;

	logic clk;
	logic arst_n;
	int   cycles;
	int   n_fail;

	fma_in_if  operands();
	fma_out_if result();

	fused_multiply_add uut (
		.clk    (clk),
		.arst_n (arst_n),
		.operands(operands.sink),
		.result (result.source)
	);

	// Result words still owed by the unit, oldest first.
	logic [WORD_W-1:0] pending_sums[$];
	logic              cur_known;
	logic [WORD_W-1:0] cur_want;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Index of the highest set bit, or -1 for zero.
	function automatic int msb256(input logic [255:0] v);
		for (int i = 255; i >= 0; i--) begin
			if (v[i]) return i;
		end
		return -1;
	endfunction

	// Exact a*b+c, rounded once to nearest even. The smaller term is
	// aligned into a 256-bit window under the larger one; anything that
	// falls off the bottom is folded into a sticky bit.
	function automatic logic [63:0] fma_result(input logic dbl, input logic [63:0] xa,
						   input logic [63:0] xb, input logic [63:0] xc);
		int fb, eb, bias, emin, xe, ye, ze, el, es, tl, ts, e0, pos, t, lsb, s, k, e;
		logic [63:0] emax, fmask, sbit, qbit, infb, dnan, ea, eb_, ec, fa, fbx, fc;
		logic [63:0] ma, mb, mc, q, sign, a, b, c;
		logic sa, sb, sc, sp, sl, ss, rnd, stk;
		logic nana, nanb, nanc, infa, infb_, infc, za, zb, zc;
		logic [255:0] L, S, lw, sw, M, tmpw;
		int ti;
		logic tsg;
		fb = dbl ? 52 : 23;
		eb = dbl ? 11 : 8;
		a = dbl ? xa : {32'b0, xa[31:0]};
		b = dbl ? xb : {32'b0, xb[31:0]};
		c = dbl ? xc : {32'b0, xc[31:0]};
		emax = (64'd1 << eb) - 1;
		fmask = (64'd1 << fb) - 1;
		sbit = 64'd1 << (fb + eb);
		qbit = 64'd1 << (fb - 1);
		infb = emax << fb;
		dnan = sbit | infb | qbit;
		bias = (1 << (eb - 1)) - 1;
		emin = 1 - bias - fb;
		ea = (a >> fb) & emax; fa = a & fmask;
		eb_ = (b >> fb) & emax; fbx = b & fmask;
		ec = (c >> fb) & emax; fc = c & fmask;
		sa = (a & sbit) != 0; sb = (b & sbit) != 0; sc = (c & sbit) != 0;
		sp = sa ^ sb;
		nana = ea == emax && fa != 0; nanb = eb_ == emax && fbx != 0;
		nanc = ec == emax && fc != 0;
		infa = ea == emax && fa == 0; infb_ = eb_ == emax && fbx == 0;
		infc = ec == emax && fc == 0;
		za = ea == 0 && fa == 0; zb = eb_ == 0 && fbx == 0; zc = ec == 0 && fc == 0;

		// Special operands, in the order the standard gives them priority.
		if (nana) return a | qbit;
		if (nanb) return b | qbit;
		if ((infa && zb) || (za && infb_)) return dnan;
		if (nanc) return c | qbit;
		if (infa || infb_) begin
			if (infc && sc != sp) return dnan;
			return (sp ? sbit : 64'd0) | infb;
		end
		if (infc) return c;
		if (za || zb) begin
			if (zc) return (sp && sc) ? sbit : 64'd0;
			return c;
		end

		ma = ea != 0 ? (fa | (64'd1 << fb)) : fa;
		xe = ea != 0 ? int'(ea) - bias - fb : emin;
		mb = eb_ != 0 ? (fbx | (64'd1 << fb)) : fbx;
		ye = eb_ != 0 ? int'(eb_) - bias - fb : emin;
		mc = ec != 0 ? (fc | (64'd1 << fb)) : fc;
		ze = ec != 0 ? int'(ec) - bias - fb : emin;

		L = 256'(ma) * 256'(mb);
		el = xe + ye;
		sl = sp;
		tl = msb256(L);
		S = 256'(mc);
		es = ze;
		ss = sc;
		ts = zc ? 0 : msb256(S);
		// The term with the higher leading bit sets the window.
		if (!zc && ze + ts > el + tl) begin
			tmpw = L; ti = el; t = tl; tsg = sl;
			L = S; el = es; tl = ts; sl = ss;
			S = tmpw; es = ti; ts = t; ss = tsg;
		end
		e0 = el + tl - WIN_TOP;
		lw = L << (WIN_TOP - tl);
		M = lw;
		sign = sl ? sbit : 64'd0;
		if (!zc) begin
			pos = es - e0;
			if (pos >= 0) begin
				sw = S << pos;
			end else if (-pos >= 256) begin
				sw = 256'd1;
			end else begin
				sw = S >> (-pos);
				if ((S & ((256'd1 << (-pos)) - 1)) != 0) sw[0] = 1'b1;
			end
			if (sl == ss) begin
				M = lw + sw;
			end else if (lw == sw) begin
				return 64'd0;
			end else if (lw > sw) begin
				M = lw - sw;
			end else begin
				M = sw - lw;
				sign = ss ? sbit : 64'd0;
			end
		end

		t = msb256(M);
		if (t < 0) return 64'd0;
		lsb = e0 + t - fb;
		if (lsb < emin) lsb = emin;
		s = lsb - e0;
		rnd = 1'b0;
		stk = 1'b0;
		if (s <= 0) begin
			q = 64'(M << (-s));
		end else begin
			q = s < 256 ? 64'(M >> s) : 64'd0;
			rnd = (s - 1 < 256) ? M[s - 1] : 1'b0;
			if (s - 1 >= 256) stk = M != 0;
			else stk = (M & ((256'd1 << (s - 1)) - 1)) != 0;
		end
		if (rnd && (stk || q[0])) q++;
		if ((q >> (fb + 1)) != 0) begin
			q >>= 1;
			lsb++;
		end
		k = lsb - emin;
		e = k + int'(q >> fb);
		if (e >= int'(emax)) return sign | infb;
		return sign | ((64'(k) << fb) + q);
	endfunction

	function automatic logic [63:0] expected_sum(input logic dbl, input logic [63:0] a,
						     input logic [63:0] b, input logic [63:0] c);
		logic [63:0] r;
		r = fma_result(dbl, a, b, c);
		return dbl ? r : {32'b0, r[31:0]};
	endfunction

	// Random operand of one precision. Special values come up often enough
	// that every rule of the standard is hit many times; the rest are
	// normals of moderate range so products and addends overlap.
	function automatic logic [63:0] rand_operand(input logic dbl);
		logic [63:0] v;
		int fb, eb, cls;
		fb = dbl ? 52 : 23;
		eb = dbl ? 11 : 8;
		v = {$urandom, $urandom};
		cls = $urandom_range(0, 19);
		case (cls)
			0: begin
				v = v & (64'd1 << (fb + eb));
			end
			1: begin
				v = (v & (64'd1 << (fb + eb))) | (((64'd1 << eb) - 1) << fb);
			end
			2: begin
				v = v | (((64'd1 << eb) - 1) << fb);
			end
			3: begin
				v = v & ~(((64'd1 << eb) - 1) << fb);
			end
			4: begin
				v = (v & ~(((64'd1 << eb) - 1) << fb))
				    | (64'($urandom_range((1 << eb) - 4, (1 << eb) - 2)) << fb);
			end
			5: begin
				v = (v & ~(((64'd1 << eb) - 1) << fb)) | (64'($urandom_range(1, 3)) << fb);
			end
			6, 7, 8: begin
				// Wholly random pattern, upper half included.
			end
			default: begin
				v = (v & ~(((64'd1 << eb) - 1) << fb))
				    | (64'(((1 << (eb - 1)) - 1) + $urandom_range(0, 40) - 20) << fb);
			end
		endcase
		// Single precision words keep random upper halves; the unit must
		// ignore them.
		if (!dbl) v[63:32] = $urandom;
		return v;
	endfunction

	// Stimulus driver: the sender may hold valid low for a while before
	// each word, then keeps it high until the unit takes the word.
	task automatic send_word(input logic cmd, input logic [63:0] a, input logic [63:0] b,
				 input logic [63:0] c, input logic known, input logic [63:0] want);
		int gap;
		gap = ($urandom_range(0, 9) < 6) ? 0 : ($urandom_range(0, 9) < 8)
		      ? $urandom_range(1, 3) : $urandom_range(8, 30);
		if ($urandom_range(0, 3) == 0) gap = 0;
		repeat (gap) begin
			operands.valid = 1'b0;
			@(negedge clk);
		end
		operands.valid  = 1'b1;
		operands.cmd    = cmd;
		operands.mult_a = a;
		operands.mult_b = b;
		operands.addend = c;
		cur_known       = known;
		cur_want        = want;
		do @(posedge clk); while (!operands.ready);
		@(negedge clk);
		operands.valid = 1'b0;
	endtask

	// Scoreboard: predictions enter when the unit accepts a word and leave
	// when the matching result word is accepted.
	always @(posedge clk) begin
		logic [63:0] want;
		if (arst_n && operands.valid && operands.ready) begin
			pending_sums.push_back(cur_known ? cur_want
				: expected_sum(operands.cmd, operands.mult_a, operands.mult_b,
					       operands.addend));
		end
		if (arst_n && result.valid && result.ready) begin
			if (pending_sums.size() == 0) begin
				$error("sum_out: unexpected word %h", result.sum_out);
				n_fail++;
			end else begin
				want = pending_sums.pop_front();
				if (result.sum_out !== want) begin
					$error("sum_out: expected %h actual %h", want, result.sum_out);
					n_fail++;
				end
			end
		end
	end

	// The receiver stalls in bursts, with calm stretches where it never does.
	initial begin
		int calm;
		result.ready = 1'b0;
		calm = 0;
		forever begin
			@(negedge clk);
			if (calm > 0) begin
				calm--;
				result.ready = 1'b1;
			end else if ($urandom_range(0, 99) == 0) begin
				calm = $urandom_range(50, 200);
				result.ready = 1'b1;
			end else if ($urandom_range(0, 99) < 3) begin
				result.ready = 1'b0;
				repeat ($urandom_range(8, 30)) @(negedge clk);
			end else begin
				result.ready = $urandom_range(0, 3) != 0;
			end
		end
	end

	// Run length watchdog.
	always @(posedge clk) begin
		cycles++;
		if (cycles > MAX_CYCLE) begin
			$display("fused_multiply_add: mismatch");
			$finish;
		end
	end

	initial begin
		stim_row_t rows[];
		logic dbl;
		logic [63:0] a, b, c, p;

		rows = '{
			// single: one times one, and the upper halves must be ignored
			'{PREC_SP, 64'h3f800000, 64'h3f800000, 64'h0, 1'b1, 64'h3f800000},
			'{PREC_SP, 64'hffffffff_3f800000, 64'hdeadbeef_3f800000,
			  64'hffffffff_00000000, 1'b1, 64'h3f800000},
			// NaN priority and quieting
			'{PREC_SP, 64'h7f800001, 64'h3f800000, 64'h0, 1'b1, 64'h7fc00001},
			'{PREC_SP, 64'h3f800000, 64'hff800005, 64'h7f800002, 1'b1, 64'hffc00005},
			'{PREC_SP, 64'h3f800000, 64'h3f800000, 64'h7f800002, 1'b1, 64'h7fc00002},
			'{PREC_SP, 64'hffffffff, 64'hffffffff, 64'hffffffff, 1'b1, 64'hffffffff},
			// infinity times zero beats a NaN addend; inf minus inf
			'{PREC_SP, 64'h7f800000, 64'h0, 64'h7f800001, 1'b1, 64'hffc00000},
			'{PREC_SP, 64'h7f800000, 64'h3f800000, 64'hff800000, 1'b1, 64'hffc00000},
			'{PREC_SP, 64'hff800000, 64'h3f800000, 64'hff800000, 1'b1, 64'hff800000},
			'{PREC_SP, 64'h3f800000, 64'h3f800000, 64'hff800000, 1'b1, 64'hff800000},
			// zero product: addend passes, or signed zero rules
			'{PREC_SP, 64'h0, 64'h3f800000, 64'h40000000, 1'b1, 64'h40000000},
			'{PREC_SP, 64'h80000000, 64'h3f800000, 64'h80000000, 1'b1, 64'h80000000},
			'{PREC_SP, 64'h80000000, 64'h3f800000, 64'h0, 1'b1, 64'h0},
			// exact cancellation, overflow, underflow to zero
			'{PREC_SP, 64'h3f800000, 64'h3f800000, 64'hbf800000, 1'b1, 64'h0},
			'{PREC_SP, 64'h7f7fffff, 64'h40000000, 64'h0, 1'b1, 64'h7f800000},
			'{PREC_SP, 64'h00000001, 64'h3f000000, 64'h0, 1'b1, 64'h0},
			// cases where a split product would round twice
			'{PREC_SP, 64'h3f800001, 64'h3f800001, 64'hbf800002, 1'b0, 64'h0},
			'{PREC_SP, 64'h00800001, 64'h3f7fffff, 64'h80000001, 1'b0, 64'h0},
			// double precision counterparts
			'{PREC_DP, 64'h3ff0000000000000, 64'h3ff0000000000000, 64'h0, 1'b1,
			  64'h3ff0000000000000},
			'{PREC_DP, 64'h7ff0000000000001, 64'h0, 64'h0, 1'b1, 64'h7ff8000000000001},
			'{PREC_DP, 64'h7ff0000000000000, 64'h0, 64'h0, 1'b1, 64'hfff8000000000000},
			'{PREC_DP, 64'h7fefffffffffffff, 64'h4000000000000000, 64'h0, 1'b1,
			  64'h7ff0000000000000},
			'{PREC_DP, 64'h3ff0000000000001, 64'h3ff0000000000001, 64'hbff0000000000002,
			  1'b0, 64'h0},
			'{PREC_DP, 64'h0000000000000001, 64'h0010000000000000, 64'h8000000000000001,
			  1'b0, 64'h0}
		};
		n_fail          = 0;
		cycles          = 0;
		arst_n          = 1'b0;
		operands.valid  = 1'b0;
		operands.cmd    = PREC_SP;
		operands.mult_a = '0;
		operands.mult_b = '0;
		operands.addend = '0;
		cur_known       = 1'b0;
		cur_want        = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (rows[i]) begin
			send_word(rows[i].cmd, rows[i].a, rows[i].b, rows[i].c, rows[i].known,
				  rows[i].want);
		end

		for (int n = 0; n < N_RANDOM; n++) begin
			// Halfway through, the sender drains the pipeline completely.
			if (n == N_RANDOM / 2) begin
				while (pending_sums.size() != 0) @(negedge clk);
			end
			dbl = 1'($urandom_range(0, 1));
			a = rand_operand(dbl);
			b = rand_operand(dbl);
			c = rand_operand(dbl);
			// A third of the addends land next to minus the product, so
			// massive cancellation and sticky rounding get real exercise.
			if ($urandom_range(0, 2) == 0) begin
				p = expected_sum(dbl, a, b, 64'd0);
				p ^= dbl ? 64'h8000000000000000 : 64'h80000000;
				p += 64'($urandom_range(0, 4)) - 64'd2;
				c = dbl ? p : {c[63:32], p[31:0]};
			end
			send_word(dbl, a, b, c, 1'b0, 64'h0);
		end

		while (pending_sums.size() != 0) @(negedge clk);
		repeat (20) @(posedge clk);
		if (n_fail == 0) begin
			$display("fused_multiply_add: match");
		end else begin
			$display("fused_multiply_add: mismatch");
		end
		$finish;
	end

endmodule
